// ===== rtl/hbl_pkg.sv =====
// Package for the half-band biquad low-pass: coefficients, widths and shared types.
package hbl_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned FracW   = 15;

  // Q15 coefficients; b0 == b2 and b1 == 2*b0, a1 is zero
  localparam logic signed [15:0] CoefB0 = 16'sd9598;
  localparam logic signed [15:0] CoefA2 = 16'sd5624;

  localparam logic signed [SampleW-1:0] SatMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SatMin = 16'sh8000;

  typedef logic signed [SampleW-1:0] sample_t;

  // Filter history: two past inputs and two past saturated outputs
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hbl_hist_t;

endpackage

// ===== rtl/hbl_mac.sv =====
// Combinational multiply-add, floor shift and saturation for one sample.
module hbl_mac (
  input  hbl_pkg::sample_t   x0_i,
  input  hbl_pkg::hbl_hist_t hist_i,
  output hbl_pkg::sample_t   y_o
);
  import hbl_pkg::*;

  logic signed [SampleW+1:0] tap_sum;
  logic signed [AccW-1:0]    acc;
  logic signed [AccW-FracW-1:0] shifted;

  // x0 + 2*x1 + x2 shares the b0 multiplier
  assign tap_sum = {{2{x0_i[SampleW-1]}}, x0_i}
                 + {hist_i.x1[SampleW-1], hist_i.x1, 1'b0}
                 + {{2{hist_i.x2[SampleW-1]}}, hist_i.x2};

  assign acc = AccW'(tap_sum) * AccW'(CoefB0)
             - AccW'(hist_i.y2) * AccW'(CoefA2);

  // arithmetic shift rounds toward minus infinity
  assign shifted = acc[AccW-1:FracW];

  // saturate to the sample range
  always_comb begin
    if (shifted > (AccW-FracW)'(SatMax)) begin
      y_o = SatMax;
    end else if (shifted < (AccW-FracW)'(SatMin)) begin
      y_o = SatMin;
    end else begin
      y_o = shifted[SampleW-1:0];
    end
  end

endmodule

// ===== rtl/halfband_biquad_lowpass_top.sv =====
// Top level of the half-band biquad low-pass filter stream block.
//
// Usage: signed 16-bit samples enter on the slave stream (s_axis_*), one
// request per sample, with s_axis_tlast marking the last sample of a blob.
// Each sample gives exactly one filtered, saturated sample on the master
// stream (m_axis_*), with tlast copied through.
// An accepted input request passes through the input register, then the
// multiply-add into the result register, which drives m_axis_tvalid.
// Throughput: one sample per cycle unless stalled; the feedback term uses
// y[n-2] only, so history written at one edge serves the next sample.
// A sample with tlast is filtered with the old history and then all four
// history registers clear, so the next blob starts from silence.
// Reset clears the pipeline valid flags and the history.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, then s_axis_tready drops until the result
// is taken.
module halfband_biquad_lowpass_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  input  logic        s_axis_tlast,   // end_of_blob
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  output logic        m_axis_tlast    // last_out
);
  import hbl_pkg::*;

  logic      in_valid_q;
  sample_t   in_x_q;
  logic      in_last_q;
  logic      out_valid_q;
  sample_t   out_y_q;
  logic      out_last_q;
  hbl_hist_t hist_q, hist_d;
  sample_t   y_calc;
  logic      advance;
  logic      s_fire;

  // pipeline flow control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_x_q    <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  hbl_mac u_mac (
    .x0_i   (in_x_q),
    .hist_i (hist_q),
    .y_o    (y_calc)
  );

  // history update: shift, or clear after the last sample of a blob
  always_comb begin
    hist_d = hist_q;
    if (advance) begin
      if (in_last_q) begin
        hist_d = '0;
      end else begin
        hist_d.x2 = hist_q.x1;
        hist_d.x1 = in_x_q;
        hist_d.y2 = hist_q.y1;
        hist_d.y1 = y_calc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_y_q    <= y_calc;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_y_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> hist_q == '0)
    else $error("history not cleared after last sample");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input not ready with empty input register");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_valid_q))
    else $error("result appeared without a sample in the input register");

  a_hist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(hist_q))
    else $error("history changed without a sample moving");

endmodule
